>>> src/fmrm_pkg.sv
// Package for the sorted multiset block: request/response words, status codes,
// controller states and the control word that is broadcast to the cell row.
// No dependencies.
package fmrm_pkg;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned RADIX  = 8;

  // request kinds
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_CLAIM  = 1'b1;

  // response status codes
  localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_MATCHED  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NO_MATCH = 2'd3;

  typedef struct packed {
    logic             req_type;
    logic [VAL_W-1:0] value;
  } fmrm_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  matched_value;
  } fmrm_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD,
    ST_RED
  } fmrm_state_e;

  // control word broadcast to every cell
  typedef struct packed {
    logic             cmp;  // compare stored value against key, latch hit
    logic             ins;  // insert key, shift larger entries right
    logic             del;  // remove last hit entry, shift larger entries left
    logic [VAL_W-1:0] key;
  } fmrm_ctrl_t;

endpackage

>>> src/fmrm_cell.sv
// One cell of the sorted row: holds one entry and its compare result, and
// trades data with its left and right neighbors on insert and remove.
// Depends on fmrm_pkg.
module fmrm_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 11
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fmrm_pkg::fmrm_ctrl_t     ctrl_i,
  input  logic [CNT_W-1:0]         count_i,
  input  logic [fmrm_pkg::VAL_W-1:0] left_data_i,
  input  logic                     left_hit_i,
  input  logic [fmrm_pkg::VAL_W-1:0] right_data_i,
  input  logic                     right_hit_i,
  input  logic                     right_hitc_i,
  output logic [fmrm_pkg::VAL_W-1:0] data_o,
  output logic                     hit_o,
  output logic                     hitc_o,
  output logic [fmrm_pkg::VAL_W-1:0] tap_o
);

  logic [fmrm_pkg::VAL_W-1:0] data_q, data_d;
  logic                       hit_q, hit_d;
  logic                       occ;

  // occupied cells compare against the broadcast key
  assign occ    = CNT_W'(IDX) < count_i;
  assign hitc_o = occ && (data_q <= ctrl_i.key);

  // the last hit cell offers its value to the reduction tree
  assign tap_o = (hitc_o && !right_hitc_i) ? data_q : '0;

  // take key or left neighbor on insert, right neighbor on remove
  always_comb begin
    data_d = data_q;
    hit_d  = hit_q;
    if (ctrl_i.cmp) begin
      hit_d = hitc_o;
    end
    if (ctrl_i.ins && !hit_q) begin
      data_d = left_hit_i ? ctrl_i.key : left_data_i;
    end else if (ctrl_i.del && !right_hit_i) begin
      data_d = right_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign hit_o  = hit_q;

endmodule

>>> src/fmrm_tree.sv
// Registered OR reduction tree, radix 8, that gathers the single nonzero tap
// of the cell row. Each level advances when en_i is high.
// Depends on fmrm_pkg.
module fmrm_tree #(
  parameter int unsigned N = 1024
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [fmrm_pkg::VAL_W-1:0] leaf_i [N],
  output logic [fmrm_pkg::VAL_W-1:0] sum_o
);

  localparam int unsigned R     = fmrm_pkg::RADIX;
  localparam int unsigned NLVL  = ($clog2(N) + 2) / 3;
  localparam int unsigned NODE0 = (N + R - 1) / R;

  logic [fmrm_pkg::VAL_W-1:0] node_q [NLVL][NODE0];
  logic [fmrm_pkg::VAL_W-1:0] node_d [NLVL][NODE0];

  // first level folds the leaves, later levels fold the level below
  for (genvar j = 0; j < NODE0; j++) begin : g_node
    always_comb begin
      node_d[0][j] = '0;
      for (int k = 0; k < R; k++) begin
        if (j * R + k < N) begin
          node_d[0][j] = node_d[0][j] | leaf_i[j * R + k];
        end
      end
    end
    for (genvar l = 1; l < NLVL; l++) begin : g_lvl
      always_comb begin
        node_d[l][j] = '0;
        for (int k = 0; k < R; k++) begin
          if (j * R + k < NODE0) begin
            node_d[l][j] = node_d[l][j] | node_q[l-1][j * R + k];
          end
        end
      end
    end
  end

  // advance all levels together
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      node_q <= node_d;
    end
  end

  assign sum_o = node_q[NLVL-1][0];

endmodule

>>> src/floor_match_remove_multiset_top.sv
// Sorted multiset of 32-bit values held in a row of CAPACITY cells, one entry
// per cell in ascending order. An insert puts its value after all equal or
// smaller entries (status full when the row is full); a claim removes and
// returns the largest entry not above its limit, or reports no match. One
// word is taken at a time. Its result is registered after the compare, the
// row update and the drain of the registered OR tree that gathers the
// claimed value from the cells, L = ceil(log8(CAPACITY)) levels deep. All
// cells compare in parallel in the compare state and shift by one position
// in the next. The result sits in an output register, so the next word is
// accepted while it waits. Depends on fmrm_pkg, fmrm_cell, fmrm_tree.
module floor_match_remove_multiset_top #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fmrm_pkg::fmrm_req_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fmrm_pkg::fmrm_rsp_t out_data_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned NLVL  = ($clog2(CAPACITY) + 2) / 3;
  localparam int unsigned LVL_W = $clog2(NLVL + 1);
  localparam int unsigned VW    = fmrm_pkg::VAL_W;

  fmrm_pkg::fmrm_state_e state_q, state_d;
  fmrm_pkg::fmrm_req_t   req_q, req_d;
  fmrm_pkg::fmrm_rsp_t   out_data_q, out_data_d, rsp;
  fmrm_pkg::fmrm_ctrl_t  ctrl;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [LVL_W-1:0]      lvl_q, lvl_d;
  logic                  full_q, full_d;
  logic                  out_valid_q, out_valid_d;
  logic                  tree_en;
  logic                  last;
  logic                  found;
  logic [VW-1:0]         tree_sum;

  logic [VW-1:0] data_w [CAPACITY];
  logic [VW-1:0] tap_w  [CAPACITY];
  logic          hit_w  [CAPACITY];
  logic          hitc_w [CAPACITY];

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VW-1:0] left_data, right_data;
    logic          left_hit, right_hit, right_hitc;

    if (i == 0) begin : g_first
      assign left_data = '0;
      assign left_hit  = 1'b1;
    end else begin : g_inner_l
      assign left_data = data_w[i-1];
      assign left_hit  = hit_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data = data_w[i];
      assign right_hit  = 1'b0;
      assign right_hitc = 1'b0;
    end else begin : g_inner_r
      assign right_data = data_w[i+1];
      assign right_hit  = hit_w[i+1];
      assign right_hitc = hitc_w[i+1];
    end

    fmrm_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .count_i      (cnt_q),
      .left_data_i  (left_data),
      .left_hit_i   (left_hit),
      .right_data_i (right_data),
      .right_hit_i  (right_hit),
      .right_hitc_i (right_hitc),
      .data_o       (data_w[i]),
      .hit_o        (hit_w[i]),
      .hitc_o       (hitc_w[i]),
      .tap_o        (tap_w[i])
    );
  end

  fmrm_tree #(
    .N (CAPACITY)
  ) u_tree (
    .clk_i  (clk_i),
    .en_i   (tree_en),
    .leaf_i (tap_w),
    .sum_o  (tree_sum)
  );

  assign found = hit_w[0];
  assign last  = lvl_q == LVL_W'(NLVL - 1);

  // build the response word
  always_comb begin
    rsp = '0;
    if (req_q.req_type == fmrm_pkg::REQ_INSERT) begin
      rsp.status = full_q ? fmrm_pkg::STAT_FULL : fmrm_pkg::STAT_INSERTED;
    end else if (found) begin
      rsp.status        = fmrm_pkg::STAT_MATCHED;
      rsp.matched_value = tree_sum;
    end else begin
      rsp.status = fmrm_pkg::STAT_NO_MATCH;
    end
  end

  // sequence one word: compare, update row, drain tree, emit
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    cnt_d       = cnt_q;
    lvl_d       = lvl_q;
    full_d      = full_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    ctrl        = '0;
    ctrl.key    = req_q.value;
    tree_en     = 1'b0;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      fmrm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d   = in_data_i;
          state_d = fmrm_pkg::ST_CMP;
        end
      end
      fmrm_pkg::ST_CMP: begin
        ctrl.cmp = 1'b1;
        tree_en  = 1'b1;
        full_d   = cnt_q == CNT_W'(CAPACITY);
        lvl_d    = '0;
        state_d  = fmrm_pkg::ST_UPD;
      end
      fmrm_pkg::ST_UPD: begin
        if (req_q.req_type == fmrm_pkg::REQ_INSERT && !full_q) begin
          ctrl.ins = 1'b1;
          cnt_d    = cnt_q + CNT_W'(1);
        end else if (req_q.req_type == fmrm_pkg::REQ_CLAIM && found) begin
          ctrl.del = 1'b1;
          cnt_d    = cnt_q - CNT_W'(1);
        end
        if (!last) begin
          tree_en = 1'b1;
          lvl_d   = lvl_q + LVL_W'(1);
        end
        state_d = fmrm_pkg::ST_RED;
      end
      fmrm_pkg::ST_RED: begin
        if (!last) begin
          tree_en = 1'b1;
          lvl_d   = lvl_q + LVL_W'(1);
        end else if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = rsp;
          state_d     = fmrm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fmrm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fmrm_pkg::ST_IDLE;
      cnt_q       <= '0;
      lvl_q       <= '0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      lvl_q       <= lvl_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> src/fmrm_checker.sv
// Port-level checker for the sorted multiset block, bound to the top level.
// Tracks words in flight and the entry count seen through the responses.
// Depends on fmrm_pkg.
module fmrm_checker #(
  parameter int unsigned CAPACITY = 1024
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input fmrm_pkg::fmrm_rsp_t out_data_o
);

  localparam int unsigned OCC_W = $clog2(CAPACITY + 1) + 1;

  logic             in_acc, out_acc;
  logic [2:0]       pend_q;
  logic [OCC_W-1:0] occ_q;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // count words in flight and entries held
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      occ_q  <= '0;
    end else begin
      pend_q <= pend_q + 3'(in_acc) - 3'(out_acc);
      if (out_acc && out_data_o.status == fmrm_pkg::STAT_INSERTED) begin
        occ_q <= occ_q + OCC_W'(1);
      end else if (out_acc && out_data_o.status == fmrm_pkg::STAT_MATCHED) begin
        occ_q <= occ_q - OCC_W'(1);
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("response changed while stalled");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 3'd0 && pend_q <= 3'd2)
    else $error("response without a matching request");

  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != fmrm_pkg::STAT_MATCHED
      |-> out_data_o.matched_value == '0)
    else $error("nonzero value on a response that removed nothing");

  a_full_only_at_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == fmrm_pkg::STAT_FULL) ==
                    (occ_q == OCC_W'(CAPACITY)) ||
                    out_data_o.status == fmrm_pkg::STAT_MATCHED ||
                    out_data_o.status == fmrm_pkg::STAT_NO_MATCH)
    else $error("full status disagrees with entry count");

  a_match_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == fmrm_pkg::STAT_MATCHED |-> occ_q != '0)
    else $error("claim matched on an empty store");

endmodule

bind floor_match_remove_multiset_top fmrm_checker #(
  .CAPACITY (CAPACITY)
) u_fmrm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

>>> tb/tb.sv
// Self-checking testbench for floor_match_remove_multiset_top: drives insert and
// claim words through the valid/ready ports and checks each result word against
// a shadow multiset. Depends on fmrm_pkg and the block's RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY   = 1024;
  localparam int unsigned CLK_PERIOD = 8;
  localparam int unsigned RST_CYCLES = 12;
  localparam int unsigned TAIL_WAIT  = 40;
  localparam int unsigned CYCLE_CAP  = 1000000;

  // Shadow copy of the sorted store plus the queue of result words still due.
  class multiset_scoreboard;
    int unsigned capacity;
    logic [fmrm_pkg::VAL_W-1:0] shadow_store[$];
    fmrm_pkg::fmrm_rsp_t result_due_q[$];
    int unsigned errors;

    function new(int unsigned cap);
      capacity = cap;
      errors   = 0;
    endfunction

    function int unsigned pending();
      return result_due_q.size();
    endfunction

    function int unsigned occupancy();
      return shadow_store.size();
    endfunction

    // Number of shadow entries that are not above key.
    function int unsigned count_not_above(logic [fmrm_pkg::VAL_W-1:0] key);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo = 0;
      hi = shadow_store.size();
      while (lo < hi) begin
        mid = lo + ((hi - lo) >> 1);
        if (shadow_store[mid] <= key) lo = mid + 1;
        else hi = mid;
      end
      return lo;
    endfunction

    // Random stored value, used to aim claim limits at live entries.
    function logic [fmrm_pkg::VAL_W-1:0] pick_stored();
      if (shadow_store.size() == 0) return $urandom;
      return shadow_store[$urandom_range(0, shadow_store.size() - 1)];
    endfunction

    // Apply an accepted request word to the shadow store and queue its result.
    function void note_request(fmrm_pkg::fmrm_req_t w);
      fmrm_pkg::fmrm_rsp_t r;
      int unsigned pos;
      r.status        = fmrm_pkg::STAT_INSERTED;
      r.matched_value = '0;
      if (w.req_type == fmrm_pkg::REQ_INSERT) begin
        if (shadow_store.size() >= capacity) begin
          r.status = fmrm_pkg::STAT_FULL;
        end else begin
          pos = count_not_above(w.value);
          shadow_store.insert(pos, w.value);
        end
      end else begin
        pos = count_not_above(w.value);
        if (pos == 0) begin
          r.status = fmrm_pkg::STAT_NO_MATCH;
        end else begin
          r.status        = fmrm_pkg::STAT_MATCHED;
          r.matched_value = shadow_store[pos-1];
          shadow_store.delete(pos - 1);
        end
      end
      result_due_q.push_back(r);
    endfunction

    // Compare a result word with the oldest one due.
    function void check_response(fmrm_pkg::fmrm_rsp_t got);
      fmrm_pkg::fmrm_rsp_t want;
      if (result_due_q.size() == 0) begin
        $display("%0t: result word with none due: expected nothing, got status %0d value %h",
                 $time, got.status, got.matched_value);
        errors++;
        return;
      end
      want = result_due_q.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d, got %0d",
                 $time, want.status, got.status);
        errors++;
      end
      if (got.matched_value !== want.matched_value) begin
        $display("%0t: matched_value mismatch: expected %h, got %h",
                 $time, want.matched_value, got.matched_value);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  fmrm_pkg::fmrm_req_t in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  fmrm_pkg::fmrm_rsp_t out_data_o;

  multiset_scoreboard sb;
  bit in_calm  = 1'b0;
  bit out_calm = 1'b0;
  int unsigned cycles = 0;

  floor_match_remove_multiset_top #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Gap length: mostly none, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Values biased toward duplicates and both ends of the range.
  function automatic logic [fmrm_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return $urandom_range(0, 31);
      5:       return $urandom_range(32'hFFFF_FFFF, 32'hFFFF_FFE0);
      default: return $urandom;
    endcase
  endfunction

  // Hold one word on the input until it is accepted, after an optional gap.
  task automatic send_word(logic kind, logic [fmrm_pkg::VAL_W-1:0] val);
    fmrm_pkg::fmrm_req_t w;
    int unsigned gap;
    w.req_type = kind;
    w.value    = val;
    if ($urandom_range(0, 99) < 2) in_calm = !in_calm;
    gap = in_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(w);
  endtask

  // Random word; claims often aim at or next to a stored value.
  task automatic send_random(int unsigned insert_pct);
    logic kind;
    logic [fmrm_pkg::VAL_W-1:0] v;
    kind = ($urandom_range(0, 99) < insert_pct) ? fmrm_pkg::REQ_INSERT
                                                 : fmrm_pkg::REQ_CLAIM;
    if (kind == fmrm_pkg::REQ_CLAIM && $urandom_range(0, 9) < 4) begin
      v = sb.pick_stored();
      case ($urandom_range(0, 2))
        0:       v = v;
        1:       v = v + 1;
        default: v = v - 1;
      endcase
    end else begin
      v = pick_value();
    end
    send_word(kind, v);
  endtask

  // Receive side: sample result words, stall ready at random.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) sb.check_response(out_data_o);
      if ($urandom_range(0, 199) == 0) out_calm = !out_calm;
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!out_calm) stall_left = pick_gap();
      end
    end
  end

  // Watchdog on total run length.
  initial begin
    while (cycles < CYCLE_CAP) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("floor_match_remove_multiset_top regression: fail");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    sb = new(CAPACITY);
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    rst_ni     <= 1'b0;
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty store, extremes, duplicates, all entries above the limit.
    send_word(fmrm_pkg::REQ_CLAIM,  32'h0000_0000);
    send_word(fmrm_pkg::REQ_CLAIM,  32'hFFFF_FFFF);
    send_word(fmrm_pkg::REQ_INSERT, 32'h0000_0000);
    send_word(fmrm_pkg::REQ_INSERT, 32'hFFFF_FFFF);
    send_word(fmrm_pkg::REQ_INSERT, 32'hFFFF_FFFF);
    send_word(fmrm_pkg::REQ_INSERT, 32'd100);
    send_word(fmrm_pkg::REQ_INSERT, 32'd100);
    send_word(fmrm_pkg::REQ_INSERT, 32'd50);
    send_word(fmrm_pkg::REQ_CLAIM,  32'd99);
    send_word(fmrm_pkg::REQ_CLAIM,  32'd100);
    send_word(fmrm_pkg::REQ_CLAIM,  32'd100);
    send_word(fmrm_pkg::REQ_CLAIM,  32'd99);
    send_word(fmrm_pkg::REQ_CLAIM,  32'd99);
    send_word(fmrm_pkg::REQ_CLAIM,  32'hFFFF_FFFE);
    send_word(fmrm_pkg::REQ_CLAIM,  32'hFFFF_FFFF);
    send_word(fmrm_pkg::REQ_INSERT, 32'd7);
    send_word(fmrm_pkg::REQ_INSERT, 32'd7);
    send_word(fmrm_pkg::REQ_INSERT, 32'hAAAA_AAAA);
    send_word(fmrm_pkg::REQ_INSERT, 32'h5555_5555);
    send_word(fmrm_pkg::REQ_CLAIM,  32'd7);
    send_word(fmrm_pkg::REQ_CLAIM,  32'h8000_0000);
    send_word(fmrm_pkg::REQ_CLAIM,  32'hFFFF_FFFF);
    send_word(fmrm_pkg::REQ_CLAIM,  32'd6);
    send_word(fmrm_pkg::REQ_CLAIM,  32'd8);

    // Mixed traffic with the store growing.
    repeat (300) send_random(65);
    // Claim-heavy traffic draining the store.
    repeat (300) send_random(35);
    repeat (26) send_random(50);

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("floor_match_remove_multiset_top regression: pass");
    end else begin
      $display("floor_match_remove_multiset_top regression: fail");
    end
    $finish;
  end

endmodule
